// ===== hdl/sor_pkg.sv =====
// Shared constants, types and helper functions for the spiral order reader.
package sor_pkg;

  localparam int MAX_ROWS   = 8;
  localparam int MAX_COLS   = 8;
  localparam int DATA_WIDTH = 32;

  localparam int CELLS     = MAX_ROWS * MAX_COLS;
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W     = $clog2(CELLS + 1);
  localparam int MAX_DIM   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int CFG_W     = 4;
  localparam int IO_W      = 32;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int JOB_DEPTH = 2;
  localparam int JPTR_W    = $clog2(JOB_DEPTH);
  localparam int JCNT_W    = $clog2(JOB_DEPTH + 1);

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [COL_W-1:0]      col_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DIM_W-1:0]      dim_t;
  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IO_W-1:0]       io_t;

  typedef struct packed {
    dim_t rows;
    dim_t cols;
  } job_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    data_t data;
  } mem_wr_t;

  typedef struct packed {
    logic run;
  } back_stat_t;

  function automatic addr_t cell_addr(input row_t r, input col_t c);
    return ADDR_W'(int'(r) * MAX_COLS + int'(c));
  endfunction

  function automatic dim_t clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
    dim_t res;
    if (v == '0) begin
      res = dim_t'(1);
    end else if (int'(v) > maxv) begin
      res = DIM_W'(maxv);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

endpackage

// ===== hdl/sor_if.sv =====
// Stream interfaces for the element input channel and the spiral result channel.
interface sor_in_if import sor_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

interface sor_out_if import sor_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] out_value;
  logic                   is_last;

  modport source (output valid, output out_value, output is_last, input ready);
  modport sink   (input valid, input out_value, input is_last, output ready);
endinterface

// ===== hdl/sor_front.sv =====
// Load front end: takes row-major elements, writes the store and queues a job per matrix.
module sor_front import sor_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  io_t     in_data,
  input  logic    hold,
  input  logic    cfg_wr,
  input  job_t    dims,
  output mem_wr_t mem_wr,
  output logic    job_push,
  output job_t    job_data
);

  row_t ld_row_r, ld_row_nxt;
  col_t ld_col_r, ld_col_nxt;
  logic accept;
  logic row_end;
  logic col_end;

  assign in_ready = !hold;
  assign accept   = in_valid && in_ready;
  assign row_end  = (ld_row_r == ROW_W'(dims.rows - 1'b1));
  assign col_end  = (ld_col_r == COL_W'(dims.cols - 1'b1));

  assign mem_wr.en   = accept;
  assign mem_wr.addr = cell_addr(ld_row_r, ld_col_r);
  assign mem_wr.data = DATA_WIDTH'($unsigned(in_data));

  assign job_push = accept && row_end && col_end;
  assign job_data = dims;

  always_comb begin
    ld_row_nxt = ld_row_r;
    ld_col_nxt = ld_col_r;
    if (cfg_wr) begin
      ld_row_nxt = '0;
      ld_col_nxt = '0;
    end else if (accept) begin
      if (col_end) begin
        ld_col_nxt = '0;
        ld_row_nxt = row_end ? '0 : ld_row_r + 1'b1;
      end else begin
        ld_col_nxt = ld_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_row_r <= '0;
      ld_col_r <= '0;
    end else begin
      ld_row_r <= ld_row_nxt;
      ld_col_r <= ld_col_nxt;
    end
  end

endmodule

// ===== hdl/sor_job_fifo.sv =====
// Small job queue between the load front end and the spiral back end.
module sor_job_fifo import sor_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  job_t              q_r [JOB_DEPTH];
  logic [JPTR_W-1:0] wr_ptr_r;
  logic [JPTR_W-1:0] rd_ptr_r;
  logic [JCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == JCNT_W'(JOB_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/sor_back.sv =====
// Spiral back end: holds the matrix store, walks the spiral and drives the result stage.
module sor_back import sor_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  mem_wr_t    mem_wr,
  input  logic       job_empty,
  input  job_t       job_data,
  output logic       job_pop,
  output back_stat_t stat,
  output logic       out_valid,
  input  logic       out_ready,
  output io_t        out_data,
  output logic       out_last
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } st_t;

  typedef enum logic [3:0] {
    DIR_RIGHT = 4'b0001,
    DIR_DOWN  = 4'b0010,
    DIR_LEFT  = 4'b0100,
    DIR_UP    = 4'b1000
  } dir_t;

  data_t mem [CELLS];
  data_t rd_data_r;

  st_t  st_r, st_nxt;
  dir_t dir_r, dir_nxt;
  row_t r_r, r_nxt, top_r, top_nxt, bot_r, bot_nxt;
  col_t c_r, c_nxt, lft_r, lft_nxt, rgt_r, rgt_nxt;
  cnt_t rem_r, rem_nxt;

  logic s1_valid_r, s1_valid_nxt;
  logic s1_last_r;
  logic out_valid_r, out_valid_nxt;
  logic out_last_r;
  io_t  out_data_r;
  logic s1_adv;
  logic issue;
  logic is_final;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign issue    = (st_r == ST_RUN) && (!s1_valid_r || s1_adv);
  assign is_final = (rem_r == '0);
  assign job_pop  = (st_r == ST_IDLE) && !job_empty;
  assign stat.run = (st_r == ST_RUN);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  always_comb begin
    st_nxt  = st_r;
    dir_nxt = dir_r;
    r_nxt   = r_r;
    c_nxt   = c_r;
    top_nxt = top_r;
    bot_nxt = bot_r;
    lft_nxt = lft_r;
    rgt_nxt = rgt_r;
    rem_nxt = rem_r;
    case (st_r)
      ST_IDLE: begin
        if (job_pop) begin
          st_nxt  = ST_RUN;
          dir_nxt = DIR_RIGHT;
          r_nxt   = '0;
          c_nxt   = '0;
          top_nxt = '0;
          lft_nxt = '0;
          bot_nxt = ROW_W'(job_data.rows - 1'b1);
          rgt_nxt = COL_W'(job_data.cols - 1'b1);
          rem_nxt = CNT_W'(int'(job_data.rows) * int'(job_data.cols) - 1);
        end
      end
      ST_RUN: begin
        if (issue) begin
          rem_nxt = rem_r - 1'b1;
          if (is_final) begin
            st_nxt = ST_IDLE;
          end else begin
            case (dir_r)
              DIR_RIGHT: begin
                if (c_r == rgt_r) begin
                  dir_nxt = DIR_DOWN;
                  top_nxt = top_r + 1'b1;
                  r_nxt   = r_r + 1'b1;
                end else begin
                  c_nxt = c_r + 1'b1;
                end
              end
              DIR_DOWN: begin
                if (r_r == bot_r) begin
                  dir_nxt = DIR_LEFT;
                  rgt_nxt = rgt_r - 1'b1;
                  c_nxt   = c_r - 1'b1;
                end else begin
                  r_nxt = r_r + 1'b1;
                end
              end
              DIR_LEFT: begin
                if (c_r == lft_r) begin
                  dir_nxt = DIR_UP;
                  bot_nxt = bot_r - 1'b1;
                  r_nxt   = r_r - 1'b1;
                end else begin
                  c_nxt = c_r - 1'b1;
                end
              end
              DIR_UP: begin
                if (r_r == top_r) begin
                  dir_nxt = DIR_RIGHT;
                  lft_nxt = lft_r + 1'b1;
                  c_nxt   = c_r + 1'b1;
                end else begin
                  r_nxt = r_r - 1'b1;
                end
              end
              default: begin
                dir_nxt = DIR_RIGHT;
              end
            endcase
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (issue) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      dir_r       <= DIR_RIGHT;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      dir_r       <= dir_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    c_r   <= c_nxt;
    top_r <= top_nxt;
    bot_r <= bot_nxt;
    lft_r <= lft_nxt;
    rgt_r <= rgt_nxt;
    rem_r <= rem_nxt;
    if (issue) begin
      s1_last_r <= is_final;
    end
    if (s1_adv) begin
      out_data_r <= IO_W'(rd_data_r);
      out_last_r <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[cell_addr(r_r, c_r)];
    end
  end

endmodule

// ===== hdl/spiral_order_reader.sv =====
// Spiral order reader top level: configuration registers, load front end, job queue, back end.
// Loading takes one element per cycle while the back end is idle and the job queue is empty.
// The last element of a matrix queues a job; the back end walks its spiral through the store
// read register and result register, streaming one result per cycle while out_ready holds.
// A new matrix is accepted once every store read of the previous spiral has issued.
// Synchronous active-low reset clears the load position, queue and walk state; sizes reset to 8.
module spiral_order_reader import sor_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  sor_in_if.sink               in_chan,
  sor_out_if.source            out_chan,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  logic [CFG_W-1:0] row_count_r;
  logic [CFG_W-1:0] col_count_r;
  logic             cfg_wr;
  logic             reg_sel;
  job_t             dims;
  mem_wr_t          mem_wr;
  logic             job_push;
  job_t             job_in;
  logic             job_full;
  logic             job_pop;
  job_t             job_out;
  logic             job_empty;
  back_stat_t       back_st;
  logic             front_hold;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    case (reg_sel)
      REG_ROW_COUNT: prdata = PDATA_W'(row_count_r);
      REG_COL_COUNT: prdata = PDATA_W'(col_count_r);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CFG_DIM_RESET;
      col_count_r <= CFG_DIM_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ROW_COUNT: row_count_r <= pwdata[CFG_W-1:0];
        REG_COL_COUNT: col_count_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign dims.rows  = clamp_dim(row_count_r, MAX_ROWS);
  assign dims.cols  = clamp_dim(col_count_r, MAX_COLS);
  assign front_hold = !job_empty || back_st.run;

  sor_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_data  (in_chan.element_value),
    .hold     (front_hold),
    .cfg_wr   (cfg_wr),
    .dims     (dims),
    .mem_wr   (mem_wr),
    .job_push (job_push),
    .job_data (job_in)
  );

  sor_job_fifo u_job_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  sor_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mem_wr    (mem_wr),
    .job_empty (job_empty),
    .job_data  (job_out),
    .job_pop   (job_pop),
    .stat      (back_st),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_chan.out_value),
    .out_last  (out_chan.is_last)
  );

  a_no_job_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("job queue overflow");

  a_stall_after_matrix: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |=> !in_chan.ready)
    else $error("input accepted before spiral drained");

  a_no_load_while_walking: assert property (@(posedge clk) disable iff (!rst_n)
    back_st.run |-> !(in_chan.valid && in_chan.ready))
    else $error("store written during spiral walk");

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for spiral_order_reader: random and directed matrices against a spiral predictor.
module tb import sor_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    io_t  value;
    logic last;
  } spiral_elem_t;

  localparam int ROW_STEP [4] = '{0, 1, 0, -1};
  localparam int COL_STEP [4] = '{1, 0, -1, 0};

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  sor_in_if  in_bus ();
  sor_out_if out_bus ();

  spiral_order_reader DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  io_t              elem_queue [$];
  spiral_elem_t     pending_spiral [$];
  data_t            elem_store [CELLS];
  logic [CFG_W-1:0] row_reg;
  logic [CFG_W-1:0] col_reg;
  int               loaded;
  int               items_sent;
  int               items_taken;
  int               err_cnt;
  logic             in_fire;
  logic             calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("spiral_order_reader: mismatch");
    $finish;
  end

  task automatic report_error(input string what);
    err_cnt++;
    $display("[%0t] ERROR: %s", $realtime, what);
  endtask

  function automatic int eff_dim(input logic [CFG_W-1:0] v, input int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic void load_element(input io_t v);
    int rows;
    int cols;
    int total;
    int r;
    int c;
    int dir;
    int nr;
    int nc;
    bit seen [CELLS];
    spiral_elem_t e;
    rows = eff_dim(row_reg, MAX_ROWS);
    cols = eff_dim(col_reg, MAX_COLS);
    total = rows * cols;
    if (loaded >= total) loaded = 0;
    elem_store[loaded] = data_t'(v);
    loaded++;
    if (loaded < total) return;
    seen = '{default: 1'b0};
    r = 0;
    c = 0;
    dir = 0;
    for (int h = 0; h < total; h++) begin
      e.value = io_t'(elem_store[r * cols + c]);
      e.last = (h == total - 1);
      pending_spiral.push_back(e);
      seen[r * cols + c] = 1'b1;
      nr = r + ROW_STEP[dir];
      nc = c + COL_STEP[dir];
      if (nr < 0 || nc < 0 || nr >= rows || nc >= cols || seen[nr * cols + nc]) begin
        dir = (dir + 1) % 4;
        nr = r + ROW_STEP[dir];
        nc = c + COL_STEP[dir];
      end
      r = nr;
      c = nc;
    end
    loaded = 0;
  endfunction

  function automatic io_t rand_elem();
    case ($urandom_range(11))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return io_t'($urandom());
    endcase
  endfunction

  // drive: element channel
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (in_bus.valid && !in_fire) begin
      in_bus.valid <= 1'b1;
    end else if (elem_queue.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
      in_bus.valid <= 1'b1;
      in_bus.element_value <= elem_queue.pop_front();
    end else begin
      in_bus.valid <= 1'b0;
    end
  end

  // drive: result backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= calm || ($urandom_range(99) >= 31);
    end
  end

  always @(posedge clk) begin : monitor
    spiral_elem_t e;
    in_fire <= in_bus.valid && in_bus.ready;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_spiral.size() == 0) begin
          report_error($sformatf("unexpected result value=%h last=%b",
                                 out_bus.out_value, out_bus.is_last));
        end else begin
          e = pending_spiral.pop_front();
          if (out_bus.out_value !== e.value)
            report_error($sformatf("out_value got %h want %h", out_bus.out_value, e.value));
          if (out_bus.is_last !== e.last)
            report_error($sformatf("is_last got %b want %b", out_bus.is_last, e.last));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        load_element(in_bus.element_value);
        items_taken++;
      end
    end
  end

  task automatic drain();
    while (items_taken != items_sent || pending_spiral.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_elems(input int n);
    for (int i = 0; i < n; i++) elem_queue.push_back(rand_elem());
    items_sent += n;
  endtask

  task automatic push_elem(input io_t v);
    elem_queue.push_back(v);
    items_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] v);
    logic [PDATA_W-1:0] data;
    data = {PDATA_W{1'b0}};
    if ($urandom_range(3) == 0) data = PDATA_W'($urandom());
    data[CFG_W-1:0] = v;
    drain();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_ROW_COUNT) row_reg = v;
    else col_reg = v;
    loaded = 0;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CFG_W-1:0] !== v)
      report_error($sformatf("register %0d reads %h want %h", idx, prdata[CFG_W-1:0], v));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_size(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
    write_reg(REG_ROW_COUNT, r);
    write_reg(REG_COL_COUNT, c);
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    if ($urandom_range(3) != 0) return CFG_W'($urandom_range(4));
    return CFG_W'($urandom_range(15));
  endfunction

  initial begin : stimulus
    int base;
    int phase_no;
    int total;
    int nmat;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.element_value = '0;
    out_bus.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_fire = 1'b0;
    calm = 1'b0;
    row_reg = CFG_DIM_RESET;
    col_reg = CFG_DIM_RESET;
    loaded = 0;
    items_sent = 0;
    items_taken = 0;
    err_cnt = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero rows acts as one: four 1x1 matrices at the value extremes
    set_size(4'd0, 4'd1);
    push_elem(32'h7FFF_FFFF);
    push_elem(32'h8000_0000);
    push_elem(32'h0000_0000);
    push_elem(32'hFFFF_FFFF);
    set_size(4'd2, 4'd2);
    for (int i = 0; i < 4; i++) push_elem(io_t'(i + 1));
    // abandon a partial load by resizing
    set_size(4'd3, 4'd3);
    for (int i = 0; i < 3; i++) push_elem(io_t'(-i - 100));
    write_reg(REG_COL_COUNT, 4'd2);
    for (int i = 0; i < 6; i++) push_elem(io_t'(i + 10));
    // oversized row count saturates
    set_size(4'd15, 4'd1);
    for (int i = 0; i < 8; i++) push_elem(io_t'(32'h1000_0000 * i + i));

    base = items_sent;
    phase_no = 0;
    while (items_sent - base < 200) begin
      phase_no++;
      drain();
      calm = (phase_no == 3);
      if (phase_no == 1) begin
        set_size(4'd8, 4'd8);
      end else if (phase_no == 2) begin
        set_size(4'd0, 4'd15);
      end else begin
        if ($urandom_range(3) != 0) write_reg(REG_ROW_COUNT, pick_size());
        if ($urandom_range(3) != 0) write_reg(REG_COL_COUNT, pick_size());
      end
      total = eff_dim(row_reg, MAX_ROWS) * eff_dim(col_reg, MAX_COLS);
      nmat = (total > 16) ? 1 : $urandom_range(1, 3);
      if (calm) nmat = (64 + total - 1) / total;
      for (int m = 0; m < nmat; m++) queue_elems(total);
      if (total > 1 && $urandom_range(3) == 0) queue_elems($urandom_range(1, total - 1));
    end

    drain();
    calm = 1'b0;
    if (err_cnt == 0) begin
      $display("spiral_order_reader: match");
    end else begin
      $display("spiral_order_reader: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sor_pkg.sv
hdl/sor_if.sv
hdl/sor_front.sv
hdl/sor_job_fifo.sv
hdl/sor_back.sv
hdl/spiral_order_reader.sv
tb/sv/tb.sv
